### design/sit_pkg.sv
// Shared types and constants for the segment intersection test pipeline.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned OUT_BITS   = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0]   fix_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic hit;
    fix_t hit_x;
    fix_t hit_y;
  } hit_t;

endpackage

`default_nettype wire

### design/segment_intersection_test.sv
// Top level: pipelined 2D segment intersection test with fixed-point hit point.
// Throughput: one transaction per cycle; the long pole is the divider, one quotient bit per stage.
// A stalled output register freezes the whole pipeline; in_ready_o follows that freeze.
// Reset (rst_ni, async, active low) clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_test #(
  parameter int unsigned FRAC_BITS = sit_pkg::FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sit_pkg::seg_pair_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sit_pkg::hit_t          out_data_o
);

  localparam int unsigned C      = sit_pkg::COORD_BITS;
  localparam int unsigned OB     = sit_pkg::OUT_BITS;
  localparam int unsigned D      = C + 1;
  localparam int unsigned PW     = 2 * D;
  localparam int unsigned NW     = 2 * D + 1;
  localparam int unsigned MW     = NW + D;
  localparam int unsigned QW     = D + FRAC_BITS + 2;
  localparam int unsigned SIDE_W = 3 + 2 * C;
  localparam int unsigned VW     = (C + FRAC_BITS + 4 > OB + 1) ? C + FRAC_BITS + 4 : OB + 1;
  localparam logic signed [VW-1:0] V_MAX = VW'((2 ** (OB - 1)) - 1);
  localparam logic signed [VW-1:0] V_MIN = -V_MAX - VW'(1);

  logic en;
  logic out_vld_q;
  sit_pkg::hit_t out_q, out_d;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: differences
  logic                  s1_vld_q;
  logic signed [C-1:0]   s1_ax_q, s1_ay_q;
  logic signed [D-1:0]   s1_s1x_q, s1_s1y_q, s1_s2x_q, s1_s2y_q, s1_dx_q, s1_dy_q;

  // stage 2: products
  logic                  s2_vld_q;
  logic signed [C-1:0]   s2_ax_q, s2_ay_q;
  logic signed [PW-1:0]  s2_p_q [6];
  logic [D-1:0]          s2_mx_q, s2_my_q;
  logic                  s2_nx_q, s2_ny_q;

  // stage 3: cross products
  logic                  s3_vld_q;
  logic signed [C-1:0]   s3_ax_q, s3_ay_q;
  logic signed [NW-1:0]  s3_den_q, s3_sn_q, s3_tn_q;
  logic [D-1:0]          s3_mx_q, s3_my_q;
  logic                  s3_nx_q, s3_ny_q;

  // stage 4: range check and magnitudes
  logic                  s4_vld_q;
  logic signed [C-1:0]   s4_ax_q, s4_ay_q;
  logic                  s4_hit_q;
  logic [NW-1:0]         s4_dabs_q, s4_tabs_q;
  logic [D-1:0]          s4_mx_q, s4_my_q;
  logic                  s4_nx_q, s4_ny_q;

  // stage 5: offset numerators
  logic                  s5_vld_q;
  logic [SIDE_W-1:0]     s5_side_q;
  logic [MW-1:0]         s5_px_q, s5_py_q;
  logic [NW-1:0]         s5_dabs_q;

  logic [1:0][NW-1:0] div_rem;
  logic [1:0][QW-1:0] div_bits;
  logic               div_vld;
  logic [1:0][QW-1:0] div_quo;
  logic [1:0]         div_rnz;
  logic [SIDE_W-1:0]  div_side;

  logic                  den_pos, s_ok, t_ok;

  assign den_pos = !s3_den_q[NW-1];
  assign s_ok = den_pos ? (!s3_sn_q[NW-1] && (s3_sn_q <= s3_den_q))
                        : ((s3_sn_q[NW-1] || s3_sn_q == '0) && (s3_sn_q >= s3_den_q));
  assign t_ok = den_pos ? (!s3_tn_q[NW-1] && (s3_tn_q <= s3_den_q))
                        : ((s3_tn_q[NW-1] || s3_tn_q == '0) && (s3_tn_q >= s3_den_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ax_q  <= in_data_i.a_start_x;
      s1_ay_q  <= in_data_i.a_start_y;
      s1_s1x_q <= D'(in_data_i.a_end_x) - D'(in_data_i.a_start_x);
      s1_s1y_q <= D'(in_data_i.a_end_y) - D'(in_data_i.a_start_y);
      s1_s2x_q <= D'(in_data_i.b_end_x) - D'(in_data_i.b_start_x);
      s1_s2y_q <= D'(in_data_i.b_end_y) - D'(in_data_i.b_start_y);
      s1_dx_q  <= D'(in_data_i.a_start_x) - D'(in_data_i.b_start_x);
      s1_dy_q  <= D'(in_data_i.a_start_y) - D'(in_data_i.b_start_y);

      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      s2_p_q[0] <= PW'(s1_s1x_q) * PW'(s1_s2y_q);
      s2_p_q[1] <= PW'(s1_s2x_q) * PW'(s1_s1y_q);
      s2_p_q[2] <= PW'(s1_s1x_q) * PW'(s1_dy_q);
      s2_p_q[3] <= PW'(s1_s1y_q) * PW'(s1_dx_q);
      s2_p_q[4] <= PW'(s1_s2x_q) * PW'(s1_dy_q);
      s2_p_q[5] <= PW'(s1_s2y_q) * PW'(s1_dx_q);
      s2_mx_q   <= s1_s1x_q[D-1] ? D'(-s1_s1x_q) : D'(s1_s1x_q);
      s2_my_q   <= s1_s1y_q[D-1] ? D'(-s1_s1y_q) : D'(s1_s1y_q);
      s2_nx_q   <= s1_s1x_q[D-1];
      s2_ny_q   <= s1_s1y_q[D-1];

      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_den_q <= NW'(s2_p_q[0]) - NW'(s2_p_q[1]);
      s3_sn_q  <= NW'(s2_p_q[2]) - NW'(s2_p_q[3]);
      s3_tn_q  <= NW'(s2_p_q[4]) - NW'(s2_p_q[5]);
      s3_mx_q  <= s2_mx_q;
      s3_my_q  <= s2_my_q;
      s3_nx_q  <= s2_nx_q;
      s3_ny_q  <= s2_ny_q;

      s4_ax_q   <= s3_ax_q;
      s4_ay_q   <= s3_ay_q;
      s4_hit_q  <= (s3_den_q != '0) && s_ok && t_ok;
      s4_dabs_q <= den_pos ? NW'(s3_den_q) : NW'(-s3_den_q);
      s4_tabs_q <= den_pos ? NW'(s3_tn_q) : NW'(-s3_tn_q);
      s4_mx_q   <= s3_mx_q;
      s4_my_q   <= s3_my_q;
      s4_nx_q   <= s3_nx_q;
      s4_ny_q   <= s3_ny_q;

      s5_side_q <= {s4_hit_q, s4_nx_q, s4_ny_q, s4_ax_q, s4_ay_q};
      s5_px_q   <= MW'(s4_tabs_q) * MW'(s4_mx_q);
      s5_py_q   <= MW'(s4_tabs_q) * MW'(s4_my_q);
      s5_dabs_q <= s4_dabs_q;

      out_q <= out_d;
    end
  end

  // offset = floor(tn * |s1| * 2^(F+1) / den), split into leading remainder and serial bits
  assign div_rem[0]  = {1'b0, s5_px_q[MW-1:D+1]};
  assign div_rem[1]  = {1'b0, s5_py_q[MW-1:D+1]};
  assign div_bits[0] = {s5_px_q[D:0], {(FRAC_BITS + 1){1'b0}}};
  assign div_bits[1] = {s5_py_q[D:0], {(FRAC_BITS + 1){1'b0}}};

  sit_div #(
    .DEN_W  (NW),
    .QUO_W  (QW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .den_i  (s5_dabs_q),
    .rem_i  (div_rem),
    .bits_i (div_bits),
    .side_i (s5_side_q),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .rnz_o  (div_rnz),
    .side_o (div_side)
  );

  function automatic logic signed [OB-1:0] fix_coord(
    input logic signed [C-1:0] st,
    input logic                neg,
    input logic                rnz,
    input logic [QW-1:0]       q
  );
    logic [QW:0]            q_up;
    logic [QW-1:0]          mag;
    logic signed [VW-1:0]   base;
    logic signed [VW-1:0]   off;
    logic signed [VW-1:0]   v;
    q_up = {1'b0, q} + (QW + 1)'(1);
    // negative direction: exact half rounds up toward zero magnitude
    mag  = (neg && !rnz) ? {1'b0, q[QW-1:1]} : q_up[QW:1];
    base = VW'(st) <<< FRAC_BITS;
    off  = signed'(VW'(mag));
    v    = neg ? base - off : base + off;
    if (v > V_MAX) begin
      v = V_MAX;
    end else if (v < V_MIN) begin
      v = V_MIN;
    end
    return v[OB-1:0];
  endfunction

  logic                 side_hit, side_nx, side_ny;
  logic signed [C-1:0]  side_ax, side_ay;

  assign side_hit = div_side[SIDE_W-1];
  assign side_nx  = div_side[SIDE_W-2];
  assign side_ny  = div_side[SIDE_W-3];
  assign side_ax  = div_side[2*C-1:C];
  assign side_ay  = div_side[C-1:0];

  always_comb begin
    out_d = '0;
    if (side_hit) begin
      out_d.hit   = 1'b1;
      out_d.hit_x = fix_coord(side_ax, side_nx, div_rnz[0], div_quo[0]);
      out_d.hit_y = fix_coord(side_ay, side_ny, div_rnz[1], div_quo[1]);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### design/sit_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps
`default_nettype none

module sit_div #(
  parameter int unsigned DEN_W  = 35,
  parameter int unsigned QUO_W  = 27,
  parameter int unsigned SIDE_W = 35
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire logic [DEN_W-1:0]             den_i,
  input  wire logic [1:0][DEN_W-1:0]        rem_i,
  input  wire logic [1:0][QUO_W-1:0]        bits_i,
  input  wire logic [SIDE_W-1:0]            side_i,
  output logic                              vld_o,
  output logic [1:0][QUO_W-1:0]             quo_o,
  output logic [1:0]                        rnz_o,
  output logic [SIDE_W-1:0]                 side_o
);

  logic                      vld_q  [QUO_W];
  logic [DEN_W-1:0]          den_q  [QUO_W];
  logic [SIDE_W-1:0]         side_q [QUO_W];
  logic [1:0][DEN_W-1:0]     rem_q  [QUO_W];
  logic [1:0][QUO_W-1:0]     bits_q [QUO_W];
  logic [1:0][QUO_W-1:0]     quo_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic                  vld_in;
    logic [DEN_W-1:0]      den_in;
    logic [SIDE_W-1:0]     side_in;
    logic [1:0][DEN_W-1:0] rem_in;
    logic [1:0][QUO_W-1:0] bits_in;
    logic [1:0][QUO_W-1:0] quo_in;
    logic [1:0][DEN_W:0]   trial;
    logic [1:0]            ge;
    logic [1:0][DEN_W-1:0] rem_d;
    logic [1:0][QUO_W-1:0] bits_d;
    logic [1:0][QUO_W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign rem_in  = rem_i;
      assign bits_in = bits_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign bits_in = bits_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign trial[l]  = {rem_in[l], bits_in[l][QUO_W-1]};
      assign ge[l]     = trial[l] >= {1'b0, den_in};
      assign rem_d[l]  = ge[l] ? DEN_W'(trial[l] - {1'b0, den_in}) : trial[l][DEN_W-1:0];
      assign bits_d[l] = {bits_in[l][QUO_W-2:0], 1'b0};
      assign quo_d[l]  = {quo_in[l][QUO_W-2:0], ge[l]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        rem_q[k]  <= rem_d;
        bits_q[k] <= bits_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign vld_o    = vld_q[QUO_W-1];
  assign quo_o    = quo_q[QUO_W-1];
  assign side_o   = side_q[QUO_W-1];
  assign rnz_o[0] = |rem_q[QUO_W-1][0];
  assign rnz_o[1] = |rem_q[QUO_W-1][1];

endmodule

`default_nettype wire

### tb/tb_segment_intersection_test.sv
// Testbench for segment_intersection_test: directed and random pairs checked against a predictor.
`timescale 1ns / 1ps

module tb_segment_intersection_test;

  localparam int LATENCY        = sit_pkg::COORD_BITS + sit_pkg::FRAC_BITS + 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 50;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  sit_pkg::seg_pair_t in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  sit_pkg::hit_t      out_data_o;

  sit_pkg::hit_t expected_hits[$];
  int   errors          = 0;
  int   pairs_sent      = 0;
  int   results_checked = 0;
  int   hits_expected   = 0;
  int   idle_cycles     = 0;
  bit   no_idle         = 1'b0;

  segment_intersection_test uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Rounded (tn/den)*d in 2^-FRAC_BITS units; 0 <= tn <= den, den > 0.
  function automatic longint scaled_offset(input longint tn, input longint den,
                                           input longint d);
    longint mag, num, quo, rem;
    mag = (d < 0) ? -d : d;
    num = tn * mag * (longint'(1) <<< (sit_pkg::FRAC_BITS + 1));
    quo = num / den;
    rem = num % den;
    if (d >= 0) return (quo + 1) >>> 1;
    if (rem == 0) return -(quo >>> 1);
    return -((quo + 1) >>> 1);
  endfunction

  function automatic sit_pkg::fix_t fix_point(input longint start, input longint off);
    longint v, hi, lo;
    hi = (longint'(1) <<< (sit_pkg::OUT_BITS - 1)) - 1;
    lo = -hi - 1;
    v  = (start <<< sit_pkg::FRAC_BITS) + off;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return sit_pkg::fix_t'(v);
  endfunction

  function automatic sit_pkg::hit_t predict_hit(input sit_pkg::seg_pair_t p);
    longint s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
    sit_pkg::hit_t res;
    res = '0;
    s1x = longint'(p.a_end_x) - longint'(p.a_start_x);
    s1y = longint'(p.a_end_y) - longint'(p.a_start_y);
    s2x = longint'(p.b_end_x) - longint'(p.b_start_x);
    s2y = longint'(p.b_end_y) - longint'(p.b_start_y);
    dx  = longint'(p.a_start_x) - longint'(p.b_start_x);
    dy  = longint'(p.a_start_y) - longint'(p.b_start_y);
    den = s1x * s2y - s2x * s1y;
    sn  = s1x * dy - s1y * dx;
    tn  = s2x * dy - s2y * dx;
    if (den == 0) return res;
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    if (sn < 0 || sn > den || tn < 0 || tn > den) return res;
    res.hit   = 1'b1;
    res.hit_x = fix_point(longint'(p.a_start_x), scaled_offset(tn, den, s1x));
    res.hit_y = fix_point(longint'(p.a_start_y), scaled_offset(tn, den, s1y));
    return res;
  endfunction

  function automatic sit_pkg::coord_t clamp_coord(input int v);
    if (v > 32767) return sit_pkg::coord_t'(32767);
    if (v < -32768) return sit_pkg::coord_t'(-32768);
    return sit_pkg::coord_t'(v);
  endfunction

  function automatic sit_pkg::seg_pair_t seg_pair(
    input int ax, input int ay, input int ex, input int ey,
    input int bx, input int by, input int fx, input int fy
  );
    sit_pkg::seg_pair_t p;
    p.a_start_x = clamp_coord(ax);
    p.a_start_y = clamp_coord(ay);
    p.a_end_x   = clamp_coord(ex);
    p.a_end_y   = clamp_coord(ey);
    p.b_start_x = clamp_coord(bx);
    p.b_start_y = clamp_coord(by);
    p.b_end_x   = clamp_coord(fx);
    p.b_end_y   = clamp_coord(fy);
    return p;
  endfunction

  function automatic int rand_offset(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Mostly crossing pairs with random content; shared ends, parallel, collinear and noise mixed in.
  function automatic sit_pkg::seg_pair_t crossing_pair();
    int cx, cy, span, ax, ay, ex, ey, mx, my, vx, vy, k;
    int unsigned kind;
    cx   = rand_offset(8000);
    cy   = rand_offset(8000);
    span = 1 << $urandom_range(13, 1);
    ax   = cx + rand_offset(span);
    ay   = cy + rand_offset(span);
    ex   = cx + rand_offset(span);
    ey   = cy + rand_offset(span);
    mx   = (ax + ex) >>> 1;
    my   = (ay + ey) >>> 1;
    vx   = rand_offset(span);
    vy   = rand_offset(span);
    kind = $urandom_range(9);
    if (kind < 6) begin
      k = $urandom_range(8, 1);
      return seg_pair(ax, ay, ex, ey, mx + vx, my + vy, mx - (vx * k) / 4, my - (vy * k) / 4);
    end else if (kind == 6) begin
      return seg_pair(ax, ay, ex, ey, ex, ey, ex + vx, ey + vy);
    end else if (kind == 7) begin
      return seg_pair(ax, ay, ex, ey, ax + vx, ay + vy, ex + vx, ey + vy);
    end else if (kind == 8) begin
      return seg_pair(ax, ay, ex, ey, ex, ey, ax, ay);
    end
    return seg_pair(ax, ay, ex, ey, cx + rand_offset(span), cy + rand_offset(span),
                    cx + rand_offset(span), cy + rand_offset(span));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("MISMATCH %s at result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
  endtask

  task automatic send_pair(input sit_pkg::seg_pair_t p);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_pair(seg_pair(-10, -10, 10, 10, -10, 10, 10, -10));
    send_pair(seg_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(seg_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(seg_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(seg_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(seg_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
    // parallel, collinear overlap, point segment on the other
    send_pair(seg_pair(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(seg_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(seg_pair(5, 5, 5, 5, 0, 0, 10, 10));
    send_pair(seg_pair(0, 0, 10, 10, 5, 5, 5, 5));
    // touching: T-junction, shared end, shared start
    send_pair(seg_pair(0, 0, 10, 0, 5, 0, 5, 10));
    send_pair(seg_pair(0, 0, 10, 0, 10, 0, 10, 10));
    send_pair(seg_pair(0, 0, 10, 5, 0, 0, -3, 7));
    // near misses
    send_pair(seg_pair(0, 0, 10, 0, 11, -5, 11, 5));
    send_pair(seg_pair(0, 0, 10, 0, 5, 1, 5, 10));
    // rounding ties on positive and negative direction, inexact negative direction
    send_pair(seg_pair(0, 0, 1, 512, -10, 1, 10, 1));
    send_pair(seg_pair(0, 0, -1, 512, -10, 1, 10, 1));
    send_pair(seg_pair(0, 0, -3, 7, -5, 3, 5, 4));
    send_pair(seg_pair(7, -2, -9, 13, -20, 1, 20, 2));
    send_pair(seg_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
    send_pair(seg_pair(-32768, 32767, 32767, -32768, 0, 0, 1, 0));
    send_pair(seg_pair(32767, 32767, -32768, 32767, 0, -32768, 0, 32767));
  endtask

  task automatic test_full_range(input int count);
    sit_pkg::seg_pair_t p;
    repeat (count) begin
      p = {$urandom(), $urandom(), $urandom(), $urandom()};
      send_pair(p);
    end
  endtask

  task automatic test_crossing(input int count);
    repeat (count) send_pair(crossing_pair());
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_crossing(count);
    no_idle = 1'b0;
  endtask

  task automatic test_drain(input int bursts, input int burst_len);
    repeat (bursts) begin
      test_crossing(burst_len);
      drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 10);
  end

  always @(posedge clk_i) begin : monitor
    sit_pkg::hit_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = predict_hit(in_data_i);
      expected_hits.push_back(want);
      pairs_sent++;
      if (want.hit) hits_expected++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result, hit", out_data_o.hit, 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", out_data_o.hit, want.hit);
        if (out_data_o.hit_x !== want.hit_x)
          report_mismatch("hit_x", out_data_o.hit_x, want.hit_x);
        if (out_data_o.hit_y !== want.hit_y)
          report_mismatch("hit_y", out_data_o.hit_y, want.hit_y);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_range(500);
    test_back_to_back(300);
    test_drain(4, 40);
    test_crossing(1000);
    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    $display("Checked %0d results for %0d segment pairs (%0d hits expected): directed,",
             results_checked, pairs_sent, hits_expected);
    $display("full-range random, back-to-back, drained bursts and crossing-biased random.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
